@@ design/heightmap_triangle_interpolator_unit_macros.svh @@
// ---------------------------------------------------------------------------
// heightmap triangle interpolator assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_TRIANGLE_INTERPOLATOR_UNIT_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_INTERPOLATOR_UNIT_MACROS_SVH

// property checked only outside reset
`define HTIU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define HTIU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/htiu_pkg.sv @@
// ---------------------------------------------------------------------------
// htiu_pkg
// types and fixed constants of the heightmap triangle interpolator
// ---------------------------------------------------------------------------
`default_nettype none

package htiu_pkg;

    // item action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_COLS   = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [1:0] CFG_WORLD_WIDTH = 2'd2;
    localparam logic [1:0] CFG_WORLD_DEPTH = 2'd3;

    // fixed point constants
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [31:0] SIGN_BIAS  = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

    // input transaction
    typedef struct packed {
        logic              action;
        logic [11:0]       vertex_index;
        logic signed [31:0] vertex_height;
        logic signed [31:0] query_x;
        logic signed [31:0] query_z;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic signed [31:0] height;
        logic              out_of_range;
    } t_out_item;

endpackage

`default_nettype wire

@@ design/heightmap_triangle_interpolator_unit.sv @@
// ---------------------------------------------------------------------------
// heightmap_triangle_interpolator_unit
// heightmap store with barycentric triangle interpolation of query points
// ---------------------------------------------------------------------------
// usage:
// - config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle
// - input channel i_in_valid / o_in_stall carries load and query transactions
// - output channel o_out_valid / i_out_stall carries one result per query
// - a load gives no result and leaves the block idle
// - a query outside the world goes from idle straight to the done state
// - an in-range query runs a bit-serial divider once per axis, one quotient
//   bit per cycle, over QW = clog2(GRID_SIDE_MAX)+16 quotient bits; one
//   shared 32x17 multiplier serves the axis scaling, the address and the
//   three weighted corner reads from the height store, which has one
//   write and one read port; the block takes no input until the result
//   is in the output register
// - reset clears the sequencer and the output valid and sets the config to
//   a 2x2 grid, ONE_Q16 world sides; the store holds nothing defined until loaded
// - a stalled result stays in the output register; loads and the next query
//   are still taken; that query waits in the done state until the result is taken
// ---------------------------------------------------------------------------
`default_nettype none

module heightmap_triangle_interpolator_unit #(
    parameter int GRID_SIDE_MAX = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire htiu_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output htiu_pkg::t_out_item       o_out_data
);

    localparam int SW    = $clog2(GRID_SIDE_MAX);
    localparam int CW    = $clog2(GRID_SIDE_MAX + 1);
    localparam int QW    = SW + 16;
    localparam int CNTW  = $clog2(QW);
    localparam int DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = 49;
    localparam int ACCW  = 48;
    localparam logic [1:0] K_LAST = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_MUL      = 10'b00_0000_0010,
        S_DLOAD    = 10'b00_0000_0100,
        S_DIV      = 10'b00_0000_1000,
        S_BASE_MUL = 10'b00_0001_0000,
        S_BASE     = 10'b00_0010_0000,
        S_READ     = 10'b00_0100_0000,
        S_MAC_MUL  = 10'b00_1000_0000,
        S_MAC_ACC  = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic                r_axis, n_axis;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [1:0]          r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic [6:0]          r_grid_cols, r_grid_rows;
    logic [31:0]         r_world_width, r_world_depth;

    // datapath registers
    logic [31:0]         r_qx, n_qx, r_qz, n_qz;
    logic                r_oor, n_oor;
    logic [MW-1:0]       r_prod, n_prod;
    logic [31:0]         r_rem, n_rem;
    logic [QW-1:0]       r_nq, n_nq;
    logic [QW-1:0]       r_sx, n_sx, r_sz, n_sz;
    logic [AW-1:0]       r_base, n_base;
    logic [ACCW-1:0]     r_acc, n_acc;
    htiu_pkg::t_out_item r_out_data, n_out_data;

    // clamped grid sides
    logic [CW-1:0]       cols_c, rows_c;
    logic [2*CW-1:0]     cells;

    always_comb begin
        if (r_grid_cols < 7'd2) begin
            cols_c = CW'(2);
        end else if (32'(r_grid_cols) > 32'(GRID_SIDE_MAX)) begin
            cols_c = CW'(GRID_SIDE_MAX);
        end else begin
            cols_c = CW'(r_grid_cols);
        end
        if (r_grid_rows < 7'd2) begin
            rows_c = CW'(2);
        end else if (32'(r_grid_rows) > 32'(GRID_SIDE_MAX)) begin
            rows_c = CW'(GRID_SIDE_MAX);
        end else begin
            rows_c = CW'(r_grid_rows);
        end
    end

    assign cells = (2*CW)'(cols_c) * (2*CW)'(rows_c);

    // input transaction decode
    logic in_accept, load_ok, oor_in;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign load_ok    = (32'(i_in_data.vertex_index) < 32'(cells));
    assign oor_in     = i_in_data.query_x[31] || i_in_data.query_z[31]
                        || ($unsigned(i_in_data.query_x) >= r_world_width)
                        || ($unsigned(i_in_data.query_z) >= r_world_depth);

    // shared multiplier
    logic [31:0]   mul_a;
    logic [16:0]   mul_b;
    logic [MW-1:0] mul_p;

    assign mul_p = {17'b0, mul_a} * {32'b0, mul_b};

    // per-axis operands
    logic [31:0]   axis_pos, div_size;
    logic [SW-1:0] side_m1;

    assign axis_pos = r_axis ? r_qz : r_qx;
    assign div_size = r_axis ? r_world_depth : r_world_width;
    assign side_m1  = r_axis ? SW'(rows_c - CW'(1)) : SW'(cols_c - CW'(1));

    // restoring division step
    logic [32:0]   rem2, rem_diff;
    logic          ge;
    logic [31:0]   step_rem;
    logic [QW-1:0] step_nq;

    assign rem2     = {r_rem, r_nq[QW-1]};
    assign rem_diff = rem2 - {1'b0, div_size};
    assign ge       = (rem2 >= {1'b0, div_size});
    assign step_rem = ge ? rem_diff[31:0] : rem2[31:0];
    assign step_nq  = {r_nq[QW-2:0], ge};

    // cell position and fractions
    logic [SW-1:0] xi, zi;
    logic [15:0]   u, v;
    logic          upper;

    assign xi    = r_sx[QW-1:16];
    assign zi    = r_sz[QW-1:16];
    assign u     = r_sx[15:0];
    assign v     = r_sz[15:0];
    assign upper = (u < v);

    // corner address and weight for the current read
    logic [AW-1:0] rd_addr;
    logic [16:0]   weight;

    always_comb begin
        case (r_k)
            2'd0: begin
                rd_addr = r_base;
                weight  = upper ? 17'(htiu_pkg::ONE_Q16) - 17'(v)
                                : 17'(htiu_pkg::ONE_Q16) - 17'(u);
            end
            2'd1: begin
                rd_addr = upper ? r_base + AW'(cols_c) : r_base + AW'(1);
                weight  = upper ? 17'(v - u) : 17'(u - v);
            end
            2'd2: begin
                rd_addr = r_base + AW'(cols_c) + AW'(1);
                weight  = upper ? 17'(u) : 17'(v);
            end
            default: begin
                rd_addr = r_base;
                weight  = '0;
            end
        endcase
    end

    // height store
    logic          ram_we;
    logic [31:0]   ram_rdata;

    assign ram_we = in_accept && (i_in_data.action == htiu_pkg::ACT_LOAD) && load_ok;

    htiu_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in_data.vertex_index)),
        .i_wdata (i_in_data.vertex_height),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // rounding and saturation of the weighted sum
    logic [ACCW:0] rnd;
    logic [32:0]   res33;
    logic [31:0]   res_sat;

    assign rnd     = {1'b0, r_acc} + (ACCW+1)'(htiu_pkg::ROUND_HALF);
    assign res33   = rnd[48:16];
    assign res_sat = res33[32] ? 32'hFFFF_FFFF : res33[31:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_qx        = r_qx;
        n_qz        = r_qz;
        n_oor       = r_oor;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_nq        = r_nq;
        n_sx        = r_sx;
        n_sz        = r_sz;
        n_base      = r_base;
        n_acc       = r_acc;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        mul_a       = '0;
        mul_b       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.action == htiu_pkg::ACT_QUERY)) begin
                    n_qx    = i_in_data.query_x;
                    n_qz    = i_in_data.query_z;
                    n_oor   = oor_in;
                    n_axis  = 1'b0;
                    n_state = oor_in ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                mul_a   = axis_pos;
                mul_b   = 17'(side_m1);
                n_prod  = mul_p;
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                n_rem   = r_prod[SW+31:SW];
                n_nq    = {r_prod[SW-1:0], 16'b0};
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = step_rem;
                n_nq  = step_nq;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(QW - 1)) begin
                    if (!r_axis) begin
                        n_sx    = step_nq;
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_sz    = step_nq;
                        n_state = S_BASE_MUL;
                    end
                end
            end
            S_BASE_MUL: begin
                mul_a   = 32'(zi);
                mul_b   = 17'(cols_c);
                n_prod  = mul_p;
                n_state = S_BASE;
            end
            S_BASE: begin
                n_base  = r_prod[AW-1:0] + AW'(xi);
                n_k     = '0;
                n_acc   = '0;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_MAC_MUL;
            end
            S_MAC_MUL: begin
                mul_a   = ram_rdata ^ htiu_pkg::SIGN_BIAS;
                mul_b   = weight;
                n_prod  = mul_p;
                n_state = S_MAC_ACC;
            end
            S_MAC_ACC: begin
                n_acc = r_acc + r_prod[ACCW-1:0];
                if (r_k == K_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data.height       = r_oor ? 32'sd0
                                                    : $signed(res_sat ^ htiu_pkg::SIGN_BIAS);
                    n_out_data.out_of_range = r_oor;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_axis        <= 1'b0;
            r_cnt         <= '0;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
            r_grid_cols   <= 7'd2;
            r_grid_rows   <= 7'd2;
            r_world_width <= htiu_pkg::ONE_Q16;
            r_world_depth <= htiu_pkg::ONE_Q16;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    htiu_pkg::CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data[6:0];
                    htiu_pkg::CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[6:0];
                    htiu_pkg::CFG_WORLD_WIDTH: r_world_width <= i_cfg_data;
                    htiu_pkg::CFG_WORLD_DEPTH: r_world_depth <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_qx       <= n_qx;
        r_qz       <= n_qz;
        r_oor      <= n_oor;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_nq       <= n_nq;
        r_sx       <= n_sx;
        r_sz       <= n_sz;
        r_base     <= n_base;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ design/htiu_ram.sv @@
// ---------------------------------------------------------------------------
// htiu_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module htiu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/htiu_checker.sv @@
// ---------------------------------------------------------------------------
// htiu_checker
// port level checks of the heightmap triangle interpolator
// ---------------------------------------------------------------------------
`default_nettype none

`include "heightmap_triangle_interpolator_unit_macros.svh"

module htiu_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire htiu_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire htiu_pkg::t_out_item o_out_data
);

    // a stalled result holds
    `HTIU_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // an accepted query occupies the block
    `HTIU_ASSERT(a_query_busy, i_in_valid && !o_in_stall && (i_in_data.action == htiu_pkg::ACT_QUERY) |=> o_in_stall, "input taken during a query")

    // an out-of-world result carries height zero
    `HTIU_ASSERT(a_oor_zero, o_out_valid && o_out_data.out_of_range |-> (o_out_data.height == 32'sd0), "out-of-range result with nonzero height")

    // reset leaves no result pending
    `HTIU_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind heightmap_triangle_interpolator_unit htiu_checker u_htiu_checker (.*);

`default_nettype wire
